>>> design/fbpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types, codes and constants of the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

   localparam int MAX_BLOCKS   = 1024;
   localparam int IDX_W        = $clog2(MAX_BLOCKS);
   localparam int CNT_W        = IDX_W + 1;
   localparam int LINK_W       = CNT_W;
   localparam int ENTRY_W      = LINK_W + 1;     // {owned, next link}
   localparam int HEADER_BYTES = 8;
   localparam int MAX_PAYLOAD  = 65536;
   localparam int SZ_W         = 17;
   localparam int BYTES_W      = 27;
   localparam int ERR_W        = 16;
   localparam int CSR_IDX_W    = 1;

   localparam logic [CNT_W-1:0]     COUNT_RESET = CNT_W'(1024);
   localparam logic [SZ_W-1:0]      BYTES_RESET = SZ_W'(64);
   localparam logic [CSR_IDX_W-1:0] REG_BLOCK_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_BLOCK_BYTES = 1'b1;

   typedef enum logic [1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_INIT  = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      RSP_ALLOCATED   = 3'd0,
      RSP_FREED       = 3'd1,
      RSP_INITIALIZED = 3'd2,
      RSP_EMPTY       = 3'd3,
      RSP_REJECTED    = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_INIT,
      S_EXEC
   } state_type;

   // accounting updates, at most one set per item
   typedef struct packed {
      logic load_init;
      logic take;
      logic give;
      logic fault;
   } acct_ctl_type;

   function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v);
      logic [CNT_W-1:0] r;
      r = v;
      if (v == '0) r = CNT_W'(1);
      else if (v > CNT_W'(MAX_BLOCKS)) r = CNT_W'(MAX_BLOCKS);
      return r;
   endfunction

   function automatic logic [SZ_W-1:0] clamp_bytes(input logic [SZ_W-1:0] v);
      logic [SZ_W-1:0] r;
      r = v;
      if (v == '0) r = SZ_W'(1);
      else if (v > SZ_W'(MAX_PAYLOAD)) r = SZ_W'(MAX_PAYLOAD);
      return r;
   endfunction

endpackage

>>> design/fbpa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module fbpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> design/fbpa_acct.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_acct
// Byte accounting: available, used, peak used and saturating error count.
// ----------------------------------------------------------------------------
module fbpa_acct import fbpa_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  acct_ctl_type       ctl,
   input  logic [CNT_W-1:0]   pool_n,
   input  logic [SZ_W-1:0]    pool_sz,
   output logic [BYTES_W-1:0] avail_bytes,
   output logic [BYTES_W-1:0] used_bytes,
   output logic [BYTES_W-1:0] peak_bytes,
   output logic [ERR_W-1:0]   errors
);

   logic [BYTES_W-1:0] avail_ff, avail_in;
   logic [BYTES_W-1:0] used_ff, used_in;
   logic [BYTES_W-1:0] peak_ff, peak_in;
   logic [ERR_W-1:0]   err_ff, err_in;
   logic [BYTES_W-1:0] sz_ext;
   logic [BYTES_W-1:0] used_up;
   logic [CNT_W+SZ_W-1:0] init_prod;

   assign sz_ext    = BYTES_W'(pool_sz);
   assign used_up   = used_ff + sz_ext;
   assign init_prod = (CNT_W+SZ_W)'(pool_n) * (CNT_W+SZ_W)'(pool_sz);

   always_comb begin
      avail_in = avail_ff;
      used_in  = used_ff;
      peak_in  = peak_ff;
      err_in   = err_ff;
      priority if (ctl.load_init) begin
         avail_in = BYTES_W'(init_prod);
         used_in  = BYTES_W'(pool_n) * BYTES_W'(HEADER_BYTES);
         peak_in  = '0;
         err_in   = '0;
      end else if (ctl.take) begin
         avail_in = avail_ff - sz_ext;
         used_in  = used_up;
         if (used_up > peak_ff) begin
            peak_in = used_up;
         end
      end else if (ctl.give) begin
         avail_in = avail_ff + sz_ext;
         used_in  = used_ff - sz_ext;
      end else if (ctl.fault) begin
         if (err_ff != '1) begin
            err_in = err_ff + ERR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avail_ff <= '0;
         used_ff  <= '0;
         peak_ff  <= '0;
         err_ff   <= '0;
      end else begin
         avail_ff <= avail_in;
         used_ff  <= used_in;
         peak_ff  <= peak_in;
         err_ff   <= err_in;
      end
   end

   assign avail_bytes = avail_ff;
   assign used_bytes  = used_ff;
   assign peak_bytes  = peak_ff;
   assign errors      = err_ff;

endmodule

>>> design/fixed_block_pool_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// LIFO free-list pool of equal-size blocks with per-block ownership flags.
//
//   channel  ports           moves
//   -------  --------------  ------------------------------------------
//   req      req_*           command + block index, one item per command
//   rsp      rsp_*           status, grant, offset and pool statistics
//   csr      csr_*           register writes (block count, block bytes)
//
// Allocate and free read the link/owned RAM when accepted, then do the
// write-back that also loads the result register.
// Initialize rewrites the link RAM one entry per cycle, one entry for each
// block of the pool size after clamping.
// After reset the pool holds no blocks until the first initialize; the RAM
// needs no clearing pass.
// A result waiting on rsp_ready does not block the next item from being
// accepted; that item's write-back waits until the result register frees.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator import fbpa_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // command channel
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_command,
   input  logic [IDX_W-1:0]     req_block_index,
   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [2:0]           rsp_status,
   output logic [IDX_W-1:0]     rsp_granted_index,
   output logic [BYTES_W-1:0]   rsp_payload_offset,
   output logic [CNT_W-1:0]     rsp_free_blocks,
   output logic [BYTES_W-1:0]   rsp_avail_bytes,
   output logic [BYTES_W-1:0]   rsp_used_bytes,
   output logic [BYTES_W-1:0]   rsp_peak_used_bytes,
   output logic [ERR_W-1:0]     rsp_error_count,
   // register write channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SZ_W-1:0]      csr_data
);

   state_type          state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [IDX_W-1:0]   addr_ff, addr_in;
   logic [IDX_W-1:0]   sweep_ff, sweep_in;
   logic [CNT_W-1:0]   head_ff, head_in;
   logic [CNT_W-1:0]   free_ff, free_in;
   logic [CNT_W-1:0]   pool_n_ff, pool_n_in;
   logic [SZ_W-1:0]    pool_sz_ff, pool_sz_in;
   logic [SZ_W-1:0]    stride_ff, stride_in;
   logic [CNT_W-1:0]   cfg_count_ff, cfg_count_in;
   logic [SZ_W-1:0]    cfg_bytes_ff, cfg_bytes_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         status_ff, status_in;
   logic [IDX_W-1:0]   granted_ff, granted_in;
   logic [BYTES_W-1:0] offset_ff, offset_in;

   cmd_type            req_cmd;
   logic               accept;
   logic               out_room;
   logic               finish;
   logic [CNT_W-1:0]   sweep_next;
   logic               sweep_last;
   logic               alloc_ok;
   logic               free_ok;
   logic [IDX_W+SZ_W-1:0] offset_prod;
   logic [CNT_W-1:0]   clamped_n;
   logic [SZ_W-1:0]    clamped_sz;

   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   logic [ENTRY_W-1:0] ram_wr_data;
   logic               ram_rd_en;
   logic [IDX_W-1:0]   ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;
   logic               ent_owned;
   logic [LINK_W-1:0]  ent_link;

   acct_ctl_type       acct_ctl;

   assign req_cmd     = cmd_type'(req_command);
   assign accept      = req_valid && req_ready;
   assign out_room    = !rsp_valid_ff || rsp_ready;
   assign finish      = (state_ff == S_EXEC) && out_room;
   assign sweep_next  = CNT_W'(sweep_ff) + CNT_W'(1);
   assign sweep_last  = sweep_next >= pool_n_ff;
   assign ent_owned   = ram_rd_data[ENTRY_W-1];
   assign ent_link    = ram_rd_data[LINK_W-1:0];
   assign alloc_ok    = (free_ff != '0) && !head_ff[IDX_W];
   assign free_ok     = (CNT_W'(addr_ff) < pool_n_ff) && ent_owned;
   assign offset_prod = (IDX_W+SZ_W)'(addr_ff) * (IDX_W+SZ_W)'(stride_ff);
   assign clamped_n   = clamp_count(cfg_count_ff);
   assign clamped_sz  = clamp_bytes(cfg_bytes_ff);

   fbpa_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_BLOCKS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   fbpa_acct u_acct (
      .clock       (clock),
      .reset       (reset),
      .ctl         (acct_ctl),
      .pool_n      (pool_n_ff),
      .pool_sz     (pool_sz_ff),
      .avail_bytes (rsp_avail_bytes),
      .used_bytes  (rsp_used_bytes),
      .peak_bytes  (rsp_peak_used_bytes),
      .errors      (rsp_error_count)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_INIT) state_in = S_INIT;
               else if (req_cmd == CMD_ALLOC || req_cmd == CMD_FREE) state_in = S_EXEC;
            end
         end
         S_INIT: begin
            if (sweep_last) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (out_room) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs and datapath next values
   always_comb begin
      req_ready    = (state_ff == S_IDLE);
      ram_rd_en    = accept && (req_cmd == CMD_ALLOC || req_cmd == CMD_FREE);
      ram_rd_addr  = (req_cmd == CMD_ALLOC) ? head_ff[IDX_W-1:0] : req_block_index;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = addr_ff;
      ram_wr_data  = {1'b0, head_ff};
      acct_ctl     = '0;

      cmd_in       = cmd_ff;
      addr_in      = addr_ff;
      sweep_in     = sweep_ff;
      head_in      = head_ff;
      free_in      = free_ff;
      pool_n_in    = pool_n_ff;
      pool_sz_in   = pool_sz_ff;
      stride_in    = stride_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      granted_in   = granted_ff;
      offset_in    = offset_ff;

      cfg_count_in = cfg_count_ff;
      cfg_bytes_in = cfg_bytes_ff;
      if (csr_valid) begin
         if (csr_index == REG_BLOCK_COUNT) cfg_count_in = csr_data[CNT_W-1:0];
         else if (csr_index == REG_BLOCK_BYTES) cfg_bytes_in = csr_data;
      end

      if (accept) begin
         cmd_in  = req_cmd;
         addr_in = ram_rd_addr;
         if (req_cmd == CMD_INIT) begin
            pool_n_in  = clamped_n;
            pool_sz_in = clamped_sz;
            stride_in  = clamped_sz + SZ_W'(HEADER_BYTES);
            sweep_in   = '0;
         end
      end

      // rebuild chain 0,1,...,n-1 and clear owned flags
      if (state_ff == S_INIT) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = sweep_ff;
         ram_wr_data = {1'b0, sweep_last ? LINK_W'(MAX_BLOCKS) : sweep_next};
         sweep_in    = sweep_ff + IDX_W'(1);
      end

      if (finish) begin
         rsp_valid_in = 1'b1;
         granted_in   = '0;
         offset_in    = '0;
         unique case (cmd_ff)
            CMD_ALLOC: begin
               if (alloc_ok) begin
                  ram_wr_en     = 1'b1;
                  ram_wr_data   = {1'b1, ent_link};
                  head_in       = ent_link;
                  free_in       = free_ff - CNT_W'(1);
                  acct_ctl.take = 1'b1;
                  status_in     = RSP_ALLOCATED;
                  granted_in    = addr_ff;
                  offset_in     = BYTES_W'(offset_prod) + BYTES_W'(HEADER_BYTES);
               end else begin
                  acct_ctl.fault = 1'b1;
                  status_in      = RSP_EMPTY;
               end
            end
            CMD_FREE: begin
               if (free_ok) begin
                  ram_wr_en     = 1'b1;
                  ram_wr_data   = {1'b0, head_ff};
                  head_in       = CNT_W'(addr_ff);
                  free_in       = free_ff + CNT_W'(1);
                  acct_ctl.give = 1'b1;
                  status_in     = RSP_FREED;
               end else begin
                  acct_ctl.fault = 1'b1;
                  status_in      = RSP_REJECTED;
               end
            end
            CMD_INIT: begin
               head_in            = '0;
               free_in            = pool_n_ff;
               acct_ctl.load_init = 1'b1;
               status_in          = RSP_INITIALIZED;
            end
            default: begin
               rsp_valid_in = rsp_valid_ff && !rsp_ready;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= LINK_W'(MAX_BLOCKS);
         free_ff      <= '0;
         pool_n_ff    <= '0;
         pool_sz_ff   <= BYTES_RESET;
         stride_ff    <= BYTES_RESET + SZ_W'(HEADER_BYTES);
         cfg_count_ff <= COUNT_RESET;
         cfg_bytes_ff <= BYTES_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         free_ff      <= free_in;
         pool_n_ff    <= pool_n_in;
         pool_sz_ff   <= pool_sz_in;
         stride_ff    <= stride_in;
         cfg_count_ff <= cfg_count_in;
         cfg_bytes_ff <= cfg_bytes_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      addr_ff    <= addr_in;
      sweep_ff   <= sweep_in;
      status_ff  <= status_in;
      granted_ff <= granted_in;
      offset_ff  <= offset_in;
   end

   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_granted_index  = granted_ff;
   assign rsp_payload_offset = offset_ff;
   assign rsp_free_blocks    = free_ff;

endmodule

>>> design/fbpa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_checker
// Port-level checks of the fixed block pool allocator, bound to the top.
// ----------------------------------------------------------------------------
module fbpa_checker import fbpa_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [2:0]         rsp_status,
   input logic [CNT_W-1:0]   rsp_free_blocks,
   input logic [BYTES_W-1:0] rsp_used_bytes,
   input logic [BYTES_W-1:0] rsp_peak_used_bytes,
   input logic [ERR_W-1:0]   rsp_error_count
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_free_blocks))
      else $error("result changed while stalled");

   a_empty_means_none_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == RSP_EMPTY |-> rsp_free_blocks == '0)
      else $error("pool empty reported with free blocks");

   a_init_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == RSP_INITIALIZED |->
         rsp_error_count == '0 && rsp_peak_used_bytes == '0 && rsp_free_blocks != '0)
      else $error("initialize did not reset statistics");

   a_peak_covers_used: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == RSP_ALLOCATED |-> rsp_peak_used_bytes >= rsp_used_bytes)
      else $error("peak below used after allocate");

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_free_blocks <= CNT_W'(MAX_BLOCKS))
      else $error("free block count out of range");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (.*);
